// ----- rtl/core/lli_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lli_pkg
// Types and widths shared by the line-line intersection block.
// ----------------------------------------------------------------------------
package lli_pkg;

  // Width of the numerators, the denominator and the raw quotient.
  localparam int NUM_W = 51;
  localparam int DEN_W = 36;
  localparam int QUO_W = 33;

  // One input beat: two lines, each as two points in signed Q8.8.
  typedef struct packed {
    logic signed [15:0] line1_start_x;
    logic signed [15:0] line1_start_y;
    logic signed [15:0] line1_end_x;
    logic signed [15:0] line1_end_y;
    logic signed [15:0] line2_start_x;
    logic signed [15:0] line2_start_y;
    logic signed [15:0] line2_end_x;
    logic signed [15:0] line2_end_y;
  } in_item_t;

  // One result beat: the crossing point in signed Q24.8.
  typedef struct packed {
    logic               hit;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic               saturated;
  } out_item_t;

  // Queue entry between the front and the back: exact numerators and denominator.
  typedef struct packed {
    logic signed [NUM_W-1:0] xnum;
    logic signed [NUM_W-1:0] ynum;
    logic signed [DEN_W-1:0] den;
  } qent_t;

endpackage

// ----- rtl/core/line_line_intersection.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_line_intersection
// Crossing point of two infinite lines by 2x2 determinants, divided in a
// pipelined restoring divider and clamped to signed Q24.8.
// ----------------------------------------------------------------------------
//  Channel | Ports                         | Beat
//  input   | in_valid, in_stall, in_item   | two lines, eight Q8.8 coordinates
//  output  | out_valid, out_stall, out_item| hit, point_x, point_y, saturated
//
// One beat is taken every cycle unless a full queue holds the front back.
// A beat passes through four front stages, the queue, a magnitude stage,
// thirty-four divider stages (an overflow check, then one quotient bit each)
// and the output register.
// Reset clears all valid bits and the queue; no clearing pass is needed.
// A stalled output freezes the divider; the front keeps filling the queue
// and stalls its input once the queue is full.
// ----------------------------------------------------------------------------
module line_line_intersection import lli_pkg::*; #(
  parameter int QDEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic  push, full, pop, empty;
  qent_t push_data, pop_data;

  // Front: determinants and products.
  lli_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .push_valid (push),
    .push_full  (full),
    .push_data  (push_data)
  );

  // Decoupling queue.
  lli_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  // Back: division and clamping.
  lli_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (empty),
    .q_data    (pop_data),
    .q_pop     (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

`ifndef SYNTHESIS
  // A parallel pair gives a zero point with no clamp.
  a_nohit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.hit) |->
      (out_item.point_x == 32'd0 && out_item.point_y == 32'd0 && !out_item.saturated))
    else $error("non-hit beat carries a point");

  // Clamping only happens on a real crossing.
  a_sat_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.saturated) |-> out_item.hit)
    else $error("saturated without hit");

  // The queue never overflows: the front holds back while it is full.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into full queue");
`endif

endmodule

// ----- rtl/core/lli_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lli_front
// Accepts line pairs and forms the exact numerators and denominator in four
// registered stages.
// ----------------------------------------------------------------------------
module lli_front import lli_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_item,
  output logic     push_valid,
  input  logic     push_full,
  output qent_t    push_data
);

  logic               en;
  logic [3:0]         v_r;

  // Stage 1: corner products and edge differences.
  logic signed [31:0] pa_r, pb_r, pc_r, pd_r;
  logic signed [16:0] dx1_r, dy1_r, dx2_r, dy2_r;
  // Stage 2: determinants and denominator products.
  logic signed [32:0] det1_r, det2_r;
  logic signed [33:0] da_r, db_r;
  logic signed [16:0] dx1b_r, dy1b_r, dx2b_r, dy2b_r;
  // Stage 3: numerator products and denominator.
  logic signed [49:0] m1_r, m2_r, m3_r, m4_r;
  logic signed [DEN_W-1:0] den3_r;
  // Stage 4: queue entry.
  qent_t              ent_r;

  // The whole front moves unless its last beat cannot enter the queue.
  assign en         = !(v_r[3] && push_full);
  assign in_stall   = !en;
  assign push_valid = v_r[3] && !push_full;
  assign push_data  = ent_r;

  // Valid bits of the four stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], in_valid};
    end
  end

  // Datapath stages.
  always_ff @(posedge clk) begin
    if (en) begin
      pa_r  <= $signed(in_item.line1_start_x) * $signed(in_item.line1_end_y);
      pb_r  <= $signed(in_item.line1_start_y) * $signed(in_item.line1_end_x);
      pc_r  <= $signed(in_item.line2_start_x) * $signed(in_item.line2_end_y);
      pd_r  <= $signed(in_item.line2_start_y) * $signed(in_item.line2_end_x);
      dx1_r <= {in_item.line1_start_x[15], in_item.line1_start_x}
             - {in_item.line1_end_x[15], in_item.line1_end_x};
      dy1_r <= {in_item.line1_start_y[15], in_item.line1_start_y}
             - {in_item.line1_end_y[15], in_item.line1_end_y};
      dx2_r <= {in_item.line2_start_x[15], in_item.line2_start_x}
             - {in_item.line2_end_x[15], in_item.line2_end_x};
      dy2_r <= {in_item.line2_start_y[15], in_item.line2_start_y}
             - {in_item.line2_end_y[15], in_item.line2_end_y};

      det1_r <= {pa_r[31], pa_r} - {pb_r[31], pb_r};
      det2_r <= {pc_r[31], pc_r} - {pd_r[31], pd_r};
      da_r   <= dx1_r * dy2_r;
      db_r   <= dy1_r * dx2_r;
      dx1b_r <= dx1_r;
      dy1b_r <= dy1_r;
      dx2b_r <= dx2_r;
      dy2b_r <= dy2_r;

      m1_r   <= det1_r * dx2b_r;
      m2_r   <= dx1b_r * det2_r;
      m3_r   <= det1_r * dy2b_r;
      m4_r   <= dy1b_r * det2_r;
      den3_r <= {{2{da_r[33]}}, da_r} - {{2{db_r[33]}}, db_r};

      ent_r.xnum <= {m1_r[49], m1_r} - {m2_r[49], m2_r};
      ent_r.ynum <= {m3_r[49], m3_r} - {m4_r[49], m4_r};
      ent_r.den  <= den3_r;
    end
  end

endmodule

// ----- rtl/core/lli_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lli_queue
// Short first-in first-out queue that decouples the front from the divider.
// ----------------------------------------------------------------------------
module lli_queue import lli_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  qent_t push_data,
  output logic  full,
  input  logic  pop,
  output qent_t pop_data,
  output logic  empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  qent_t         mem [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem[rp_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= push_data;
    end
  end

endmodule

// ----- rtl/core/lli_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lli_back
// Pipelined restoring divider, one quotient bit a stage, with clamping and
// the output register.
// ----------------------------------------------------------------------------
module lli_back import lli_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  qent_t     q_data,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int HI = NUM_W - QUO_W;

  // One division step: shift in a numerator bit and subtract when possible.
  function automatic logic [DEN_W:0] div_step(input logic [DEN_W-1:0] r,
                                              input logic [DEN_W-1:0] d,
                                              input logic nb);
    logic [DEN_W:0] t;
    logic [DEN_W:0] s;
    t = {r, nb};
    s = t - {1'b0, d};
    if (!s[DEN_W]) begin
      return {1'b1, s[DEN_W-1:0]};
    end else begin
      return {1'b0, t[DEN_W-1:0]};
    end
  endfunction

  logic en;

  // Magnitude stage.
  logic             a_v_r, a_xneg_r, a_yneg_r, a_dz_r;
  logic [NUM_W-1:0] a_xm_r, a_ym_r;
  logic [DEN_W-1:0] a_dm_r;

  // Divider stages 0..QUO_W.
  logic             s_v_r    [QUO_W+1];
  logic             s_xneg_r [QUO_W+1];
  logic             s_yneg_r [QUO_W+1];
  logic             s_dz_r   [QUO_W+1];
  logic             s_xov_r  [QUO_W+1];
  logic             s_yov_r  [QUO_W+1];
  logic [DEN_W-1:0] s_dm_r   [QUO_W+1];
  logic [QUO_W-1:0] s_xn_r   [QUO_W+1];
  logic [QUO_W-1:0] s_yn_r   [QUO_W+1];
  logic [DEN_W-1:0] s_xr_r   [QUO_W+1];
  logic [DEN_W-1:0] s_yr_r   [QUO_W+1];
  logic [QUO_W-1:0] s_xq_r   [QUO_W+1];
  logic [QUO_W-1:0] s_yq_r   [QUO_W+1];

  logic             o_v_r;
  out_item_t        o_item_r;

  logic             xov_init, yov_init;
  logic [DEN_W:0]   xstep [QUO_W];
  logic [DEN_W:0]   ystep [QUO_W];
  logic [QUO_W-1:0] fq_x, fq_y;
  logic             fsat_x, fsat_y;
  logic [31:0]      fpx, fpy;

  // The back moves whenever the output register is free or being taken.
  assign en        = !o_v_r || !out_stall;
  assign q_pop     = en && !q_empty;
  assign out_valid = o_v_r;
  assign out_item  = o_item_r;

  // Overflow when the quotient needs more than QUO_W bits.
  assign xov_init = ({{(DEN_W-HI){1'b0}}, a_xm_r[NUM_W-1:QUO_W]} >= a_dm_r);
  assign yov_init = ({{(DEN_W-HI){1'b0}}, a_ym_r[NUM_W-1:QUO_W]} >= a_dm_r);

  // Division steps, one per stage.
  always_comb begin
    for (int i = 0; i < QUO_W; i++) begin
      xstep[i] = div_step(s_xr_r[i], s_dm_r[i], s_xn_r[i][QUO_W-1-i]);
      ystep[i] = div_step(s_yr_r[i], s_dm_r[i], s_yn_r[i][QUO_W-1-i]);
    end
  end

  // Clamp and sign of the final quotients.
  always_comb begin
    fq_x   = s_xq_r[QUO_W];
    fq_y   = s_yq_r[QUO_W];
    fsat_x = s_xov_r[QUO_W] || fq_x[QUO_W-1]
           || (fq_x[31] && (!s_xneg_r[QUO_W] || (|fq_x[30:0])));
    fsat_y = s_yov_r[QUO_W] || fq_y[QUO_W-1]
           || (fq_y[31] && (!s_yneg_r[QUO_W] || (|fq_y[30:0])));
    if (fsat_x) begin
      fpx = s_xneg_r[QUO_W] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      fpx = s_xneg_r[QUO_W] ? (32'd0 - fq_x[31:0]) : fq_x[31:0];
    end
    if (fsat_y) begin
      fpy = s_yneg_r[QUO_W] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      fpy = s_yneg_r[QUO_W] ? (32'd0 - fq_y[31:0]) : fq_y[31:0];
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      o_v_r <= 1'b0;
      for (int i = 0; i <= QUO_W; i++) begin
        s_v_r[i] <= 1'b0;
      end
    end else if (en) begin
      a_v_r    <= !q_empty;
      s_v_r[0] <= a_v_r;
      for (int i = 0; i < QUO_W; i++) begin
        s_v_r[i+1] <= s_v_r[i];
      end
      o_v_r <= s_v_r[QUO_W];
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (en) begin
      a_xneg_r <= q_data.xnum[NUM_W-1] ^ q_data.den[DEN_W-1];
      a_yneg_r <= q_data.ynum[NUM_W-1] ^ q_data.den[DEN_W-1];
      a_dz_r   <= (q_data.den == '0);
      a_xm_r   <= q_data.xnum[NUM_W-1] ? (NUM_W'(0) - q_data.xnum) : q_data.xnum;
      a_ym_r   <= q_data.ynum[NUM_W-1] ? (NUM_W'(0) - q_data.ynum) : q_data.ynum;
      a_dm_r   <= q_data.den[DEN_W-1] ? (DEN_W'(0) - q_data.den) : q_data.den;

      s_xneg_r[0] <= a_xneg_r;
      s_yneg_r[0] <= a_yneg_r;
      s_dz_r[0]   <= a_dz_r;
      s_dm_r[0]   <= a_dm_r;
      s_xov_r[0]  <= xov_init;
      s_yov_r[0]  <= yov_init;
      s_xn_r[0]   <= a_xm_r[QUO_W-1:0];
      s_yn_r[0]   <= a_ym_r[QUO_W-1:0];
      s_xr_r[0]   <= xov_init ? '0 : {{(DEN_W-HI){1'b0}}, a_xm_r[NUM_W-1:QUO_W]};
      s_yr_r[0]   <= yov_init ? '0 : {{(DEN_W-HI){1'b0}}, a_ym_r[NUM_W-1:QUO_W]};
      s_xq_r[0]   <= '0;
      s_yq_r[0]   <= '0;

      for (int i = 0; i < QUO_W; i++) begin
        s_xneg_r[i+1] <= s_xneg_r[i];
        s_yneg_r[i+1] <= s_yneg_r[i];
        s_dz_r[i+1]   <= s_dz_r[i];
        s_dm_r[i+1]   <= s_dm_r[i];
        s_xov_r[i+1]  <= s_xov_r[i];
        s_yov_r[i+1]  <= s_yov_r[i];
        s_xn_r[i+1]   <= s_xn_r[i];
        s_yn_r[i+1]   <= s_yn_r[i];
        s_xr_r[i+1]   <= xstep[i][DEN_W-1:0];
        s_yr_r[i+1]   <= ystep[i][DEN_W-1:0];
        s_xq_r[i+1]   <= {s_xq_r[i][QUO_W-2:0], xstep[i][DEN_W]};
        s_yq_r[i+1]   <= {s_yq_r[i][QUO_W-2:0], ystep[i][DEN_W]};
      end

      if (s_dz_r[QUO_W]) begin
        o_item_r <= '0;
      end else begin
        o_item_r.hit       <= 1'b1;
        o_item_r.point_x   <= fpx;
        o_item_r.point_y   <= fpy;
        o_item_r.saturated <= fsat_x || fsat_y;
      end
    end
  end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives pairs of lines into the intersection block and checks every result
// beat against a predictor built on exact 64-bit integer arithmetic, with
// random idling on both channels and one pause that drains the block.
// ----------------------------------------------------------------------------
module testbench;
  import lli_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  in_item_t  pending_pairs[$];
  out_item_t expected_points[$];
  bit        failed;
  bit        stim_done;
  bit        idle_on;
  bit        drain_hold;
  int        quiet_cycles;
  localparam int WATCHDOG = 5000;

  line_line_intersection dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  // Clock with a 20 ns period.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Compute the expected crossing point of one pair of lines.
  function automatic out_item_t cross_point(in_item_t p);
    longint x1, y1, x2, y2, x3, y3, x4, y4;
    longint det1, det2, dx1, dy1, dx2, dy2, xnum, ynum, den, qx, qy;
    out_item_t r;
    x1 = p.line1_start_x; y1 = p.line1_start_y;
    x2 = p.line1_end_x;   y2 = p.line1_end_y;
    x3 = p.line2_start_x; y3 = p.line2_start_y;
    x4 = p.line2_end_x;   y4 = p.line2_end_y;
    det1 = x1 * y2 - y1 * x2;
    det2 = x3 * y4 - y3 * x4;
    dx1 = x1 - x2; dy1 = y1 - y2;
    dx2 = x3 - x4; dy2 = y3 - y4;
    xnum = det1 * dx2 - dx1 * det2;
    ynum = det1 * dy2 - dy1 * det2;
    den = dx1 * dy2 - dy1 * dx2;
    r = '0;
    if (den != 0) begin
      // SystemVerilog integer division truncates toward zero.
      qx = xnum / den;
      qy = ynum / den;
      r.hit = 1'b1;
      if (qx > 64'sd2147483647) begin
        qx = 64'sd2147483647; r.saturated = 1'b1;
      end else if (qx < -64'sd2147483648) begin
        qx = -64'sd2147483648; r.saturated = 1'b1;
      end
      if (qy > 64'sd2147483647) begin
        qy = 64'sd2147483647; r.saturated = 1'b1;
      end else if (qy < -64'sd2147483648) begin
        qy = -64'sd2147483648; r.saturated = 1'b1;
      end
      r.point_x = qx[31:0];
      r.point_y = qy[31:0];
    end
    return r;
  endfunction

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 15)) - 16'd8;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_item_t rand_pair();
    in_item_t p;
    int kind;
    p = in_item_t'({$urandom, $urandom, $urandom, $urandom});
    kind = $urandom_range(0, 9);
    if (kind < 3) begin
      p.line1_start_x = rand_coord(); p.line1_start_y = rand_coord();
      p.line1_end_x = rand_coord();   p.line1_end_y = rand_coord();
      p.line2_start_x = rand_coord(); p.line2_start_y = rand_coord();
      p.line2_end_x = rand_coord();   p.line2_end_y = rand_coord();
    end else if (kind == 3) begin
      // Parallel: second line is the first shifted.
      p.line2_end_x = p.line2_start_x + (p.line1_end_x - p.line1_start_x);
      p.line2_end_y = p.line2_start_y + (p.line1_end_y - p.line1_start_y);
    end else if (kind == 4) begin
      // Nearly parallel lines give large quotients and saturation.
      p.line2_end_x = p.line2_start_x + (p.line1_end_x - p.line1_start_x);
      p.line2_end_y = p.line2_start_y + (p.line1_end_y - p.line1_start_y)
                      + 16'($urandom_range(0, 2)) - 16'd1;
    end else if (kind == 5) begin
      // Degenerate first line.
      p.line1_end_x = p.line1_start_x;
      p.line1_end_y = p.line1_start_y;
    end
    return p;
  endfunction

  function automatic in_item_t mk(int a, int b, int c, int d, int e, int f, int g, int h);
    in_item_t p;
    p.line1_start_x = 16'(a); p.line1_start_y = 16'(b);
    p.line1_end_x = 16'(c);   p.line1_end_y = 16'(d);
    p.line2_start_x = 16'(e); p.line2_start_y = 16'(f);
    p.line2_end_x = 16'(g);   p.line2_end_y = 16'(h);
    return p;
  endfunction

  // Input driver: one pending pair per beat, random idling.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_item <= '0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid && !in_stall)
        expected_points.push_back(cross_point(in_item));
      if (pending_pairs.size() > 0 && !drain_hold &&
          !(idle_on && $urandom_range(0, 99) < 12)) begin
        in_valid <= 1'b1;
        in_item <= pending_pairs.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output monitor and stall generator.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_points.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, out_item);
          failed = 1'b1;
        end else begin
          out_item_t e;
          e = expected_points.pop_front();
          if (e.hit !== out_item.hit)
            $display("%0t: hit expected %0d actual %0d", $time, e.hit, out_item.hit);
          if (e.point_x !== out_item.point_x)
            $display("%0t: point_x expected %0d actual %0d", $time, e.point_x,
                     out_item.point_x);
          if (e.point_y !== out_item.point_y)
            $display("%0t: point_y expected %0d actual %0d", $time, e.point_y,
                     out_item.point_y);
          if (e.saturated !== out_item.saturated)
            $display("%0t: saturated expected %0d actual %0d", $time, e.saturated,
                     out_item.saturated);
          if (e !== out_item)
            failed = 1'b1;
        end
      end
      out_stall <= idle_on && ($urandom_range(0, 99) < 12);
    end
  end

  // Watchdog on cycles with no accepted beat.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG && !stim_done) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    failed = 1'b0;
    stim_done = 1'b0;
    idle_on = 1'b1;
    drain_hold = 1'b0;
    // Directed pairs: crossings, parallel, coincident, degenerate, extremes.
    pending_pairs.push_back(mk(0, 0, 256, 256, 0, 256, 256, 0));
    pending_pairs.push_back(mk(-256, 0, 256, 0, 0, -256, 0, 256));
    pending_pairs.push_back(mk(0, 0, 256, 0, 0, 256, 256, 256));
    pending_pairs.push_back(mk(0, 0, 256, 256, 512, 512, 768, 768));
    pending_pairs.push_back(mk(5, 5, 5, 5, 0, 0, 1, 3));
    pending_pairs.push_back(mk(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    pending_pairs.push_back(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768,
                               -32768));
    pending_pairs.push_back(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    pending_pairs.push_back(mk(-32768, 0, 32767, 1, -32768, 1, 32767, 2));
    pending_pairs.push_back(mk(-32768, 0, 32767, 0, -32768, 1, 32767, 0));
    pending_pairs.push_back(mk(-32768, 32767, 32767, 32767, -32768, 32766, 32767,
                               32767));
    pending_pairs.push_back(mk(1, 0, 0, 1, 3, -7, -5, 2));
    pending_pairs.push_back(mk(-1, -1, 1, 2, 7, -3, -2, 5));
    pending_pairs.push_back(mk(32767, -32768, -32768, 32767, 0, 0, 1, 1));
    pending_pairs.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0));
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < 1135; i++) begin
      pending_pairs.push_back(rand_pair());
      // A long stretch with no idling, and one pause that drains the block.
      if (i == 300) begin
        wait (pending_pairs.size() == 0);
        idle_on = 1'b0;
      end
      if (i == 600) begin
        wait (pending_pairs.size() == 0);
        idle_on = 1'b1;
        drain_hold = 1'b1;
        wait (expected_points.size() == 0 && !in_valid);
        @(posedge clk);
        drain_hold = 1'b0;
      end
    end
    wait (pending_pairs.size() == 0);
    @(posedge clk);
    wait (!in_valid || !in_stall);
    fork
      begin
        wait (expected_points.size() == 0 && !in_valid);
        repeat (60) @(posedge clk);
      end
      begin
        repeat (WATCHDOG * 4) @(posedge clk);
        failed = 1'b1;
        $display("%0t: results still missing at the end", $time);
      end
    join_any
    stim_done = 1'b1;
    if (expected_points.size() != 0 || failed)
      $display("tb: failure");
    else
      $display("tb: success");
    $finish;
  end

endmodule
